FILE: rtl/mrpt_pkg.sv
`default_nettype none
package mrpt_pkg;
	localparam int Width = 64;
	localparam int NumBases = 12;
	localparam int BaseIdxW = 4;
	localparam int CntW = 7;
	localparam int ShW = 7;
	localparam int NumTrial = 7;

	typedef enum logic [1:0] {
		KIND_NOT_PRIME,
		KIND_PRIME,
		KIND_TEST
	} kind_t;

	typedef struct packed {
		kind_t              kind;
		logic [Width-1:0]   n;
	} job_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SPLIT,
		ST_BASE,
		ST_EXP_STEP,
		ST_MUL_WAIT,
		ST_CHECK,
		ST_SQ_START,
		ST_SQ_WAIT,
		ST_DONE
	} state_t;

	function automatic logic [5:0] base_value(input logic [BaseIdxW-1:0] idx);
		logic [5:0] v;
		begin
			case (idx)
				4'd0: v = 6'd2;
				4'd1: v = 6'd3;
				4'd2: v = 6'd5;
				4'd3: v = 6'd7;
				4'd4: v = 6'd11;
				4'd5: v = 6'd13;
				4'd6: v = 6'd17;
				4'd7: v = 6'd19;
				4'd8: v = 6'd23;
				4'd9: v = 6'd29;
				4'd10: v = 6'd31;
				4'd11: v = 6'd37;
				default: v = 6'd2;
			endcase
			return v;
		end
	endfunction
endpackage
`default_nettype wire

FILE: rtl/mrpt_front.sv
`default_nettype none
// Classifies each candidate: below two, divisible by a small prime, or needing rounds.
// The residues modulo all seven primes are updated side by side, one candidate bit per
// cycle from the top bit down, through all 64 bits.
module mrpt_front import mrpt_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire logic [Width-1:0] in_n,
	output logic                  job_valid,
	input  wire logic             job_ready,
	output job_t                  job
);
	logic             busy_q;
	logic [Width-1:0] n_q;
	logic [CntW-1:0]  bit_q;
	logic [5:0]       rem_q [NumTrial];
	logic             out_valid_q;
	job_t             job_q;
	logic [5:0]       rem_nx [NumTrial];
	kind_t            kind_c;
	logic             hit;

	always_comb begin
		for (int i = 0; i < NumTrial; i++) begin
			logic [6:0] t;
			t = {rem_q[i], n_q[Width - 1 - bit_q[5:0]]};
			if (t >= {1'b0, base_value(BaseIdxW'(i))})
				t = t - {1'b0, base_value(BaseIdxW'(i))};
			rem_nx[i] = t[5:0];
		end
	end

	always_comb begin
		hit = 1'b0;
		kind_c = KIND_TEST;
		for (int i = NumTrial - 1; i >= 0; i--) begin
			if (rem_q[i] == 6'd0) begin
				hit = 1'b1;
				kind_c = (n_q == Width'(base_value(BaseIdxW'(i)))) ? KIND_PRIME
					: KIND_NOT_PRIME;
			end
		end
		if (n_q < Width'(2))
			kind_c = KIND_NOT_PRIME;
		else if (!hit)
			kind_c = KIND_TEST;
	end

	assign in_ready  = !busy_q && !out_valid_q;
	assign job_valid = out_valid_q;
	assign job       = job_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
			bit_q       <= '0;
		end else begin
			if (in_valid && in_ready) begin
				busy_q <= 1'b1;
				bit_q  <= '0;
			end else if (busy_q) begin
				if (bit_q == CntW'(Width)) begin
					busy_q      <= 1'b0;
					out_valid_q <= 1'b1;
				end else begin
					bit_q <= bit_q + 1'b1;
				end
			end
			if (out_valid_q && job_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			n_q <= in_n;
			for (int i = 0; i < NumTrial; i++)
				rem_q[i] <= '0;
		end else if (busy_q) begin
			if (bit_q == CntW'(Width)) begin
				job_q.kind <= kind_c;
				job_q.n    <= n_q;
			end else begin
				for (int i = 0; i < NumTrial; i++)
					rem_q[i] <= rem_nx[i];
			end
		end
	end
endmodule
`default_nettype wire

FILE: rtl/mrpt_queue.sv
`default_nettype none
// Two-entry queue of classified jobs between the front and the back.
module mrpt_queue import mrpt_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic wr_valid,
	output logic      wr_ready,
	input  wire job_t wr_job,
	output logic      rd_valid,
	input  wire logic rd_ready,
	output job_t      rd_job
);
	job_t       mem_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	logic       wr, rd;

	assign wr_ready = cnt_q != 2'd2;
	assign rd_valid = cnt_q != 2'd0;
	assign rd_job   = mem_q[rp_q];
	assign wr = wr_valid && wr_ready;
	assign rd = rd_valid && rd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (wr) wp_q <= !wp_q;
			if (rd) rp_q <= !rp_q;
			cnt_q <= cnt_q + {1'b0, wr} - {1'b0, rd};
		end
	end

	always_ff @(posedge clk) begin
		if (wr) mem_q[wp_q] <= wr_job;
	end
endmodule
`default_nettype wire

FILE: rtl/mrpt_mulmod.sv
`default_nettype none
// (a * b) mod m by shift-and-add, one bit of b per cycle.
module mrpt_mulmod import mrpt_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [Width-1:0] a,
	input  wire logic [Width-1:0] b,
	input  wire logic [Width-1:0] m,
	output logic                  done,
	output logic [Width-1:0]      r
);
	logic             busy_q, done_q;
	logic [CntW-1:0]  cnt_q;
	logic [Width-1:0] a_q, b_q, m_q, r_q;
	logic [Width:0]   dbl, add;

	always_comb begin
		dbl = {r_q, 1'b0};
		if (dbl >= {1'b0, m_q}) dbl = dbl - {1'b0, m_q};
		add = dbl;
		if (b_q[Width-1]) begin
			add = dbl + {1'b0, a_q};
			if (add >= {1'b0, m_q}) add = add - {1'b0, m_q};
		end
	end

	assign done = done_q;
	assign r    = r_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CntW'(Width - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= a;
			b_q <= b;
			m_q <= m;
			r_q <= '0;
		end else if (busy_q) begin
			r_q <= add[Width-1:0];
			b_q <= {b_q[Width-2:0], 1'b0};
		end
	end
endmodule
`default_nettype wire

FILE: rtl/mrpt_back.sv
`default_nettype none
// Runs the witness rounds for a job that the front could not settle and passes on the verdict of one that it could.
module mrpt_back import mrpt_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic job_valid,
	output logic      job_ready,
	input  wire job_t job,
	output logic      res_valid,
	input  wire logic res_ready,
	output logic      res_prime
);
	state_t           state_q, state_d;
	logic [Width-1:0] n_q, d_q, e_q, a_q, x_q;
	logic [ShW-1:0]   s_q, r_q;
	logic [BaseIdxW-1:0] bi_q;
	logic             mul_sel_q;
	logic             prime_q;
	logic             mstart;
	logic [Width-1:0] ma, mb;
	logic             mdone;
	logic [Width-1:0] mr;
	logic [Width-1:0] nm1;
	logic [Width-1:0] base_w;

	assign nm1    = n_q - Width'(1);
	assign base_w = Width'(base_value(bi_q));

	mrpt_mulmod u_mul (
		.clk(clk), .arst_n(arst_n), .start(mstart), .a(ma), .b(mb), .m(n_q),
		.done(mdone), .r(mr)
	);

	assign job_ready = state_q == ST_IDLE;
	assign res_valid = state_q == ST_DONE;
	assign res_prime = prime_q;

	always_comb begin
		state_d = state_q;
		mstart  = 1'b0;
		ma      = x_q;
		mb      = a_q;
		case (state_q)
			ST_IDLE: if (job_valid) state_d = (job.kind == KIND_TEST) ? ST_SPLIT : ST_DONE;
			ST_SPLIT: if (d_q[0]) state_d = ST_BASE;
			ST_BASE: begin
				if (bi_q == BaseIdxW'(NumBases)) state_d = ST_DONE;
				else if (base_w >= n_q) state_d = ST_BASE;
				else state_d = ST_EXP_STEP;
			end
			ST_EXP_STEP: begin
				if (e_q == '0) state_d = ST_CHECK;
				else begin
					mstart = 1'b1;
					ma = e_q[0] ? x_q : a_q;
					mb = a_q;
					state_d = ST_MUL_WAIT;
				end
			end
			ST_MUL_WAIT: begin
				if (mdone) begin
					if (!mul_sel_q && e_q[0]) begin
						mstart = 1'b1;
						ma = a_q;
						mb = a_q;
						state_d = ST_MUL_WAIT;
					end else state_d = ST_EXP_STEP;
				end
			end
			ST_CHECK: begin
				if (x_q == Width'(1) || x_q == nm1) state_d = ST_BASE;
				else if (r_q >= s_q) state_d = ST_DONE;
				else state_d = ST_SQ_START;
			end
			ST_SQ_START: begin
				mstart = 1'b1;
				ma = x_q;
				mb = x_q;
				state_d = ST_SQ_WAIT;
			end
			ST_SQ_WAIT: begin
				if (mdone) begin
					if (mr == nm1) state_d = ST_BASE;
					else if (r_q + 1'b1 >= s_q) state_d = ST_DONE;
					else state_d = ST_SQ_START;
				end
			end
			ST_DONE: if (res_ready) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: if (job_valid) begin
				n_q     <= job.n;
				d_q     <= job.n - Width'(1);
				s_q     <= '0;
				bi_q    <= '0;
				prime_q <= job.kind == KIND_PRIME;
			end
			ST_SPLIT: if (!d_q[0]) begin
				d_q <= d_q >> 1;
				s_q <= s_q + 1'b1;
			end else prime_q <= 1'b1;
			ST_BASE: begin
				if (bi_q != BaseIdxW'(NumBases)) begin
					bi_q <= bi_q + 1'b1;
					a_q  <= base_w;
					e_q  <= d_q;
					x_q  <= Width'(1);
					r_q  <= ShW'(1);
				end
			end
			ST_EXP_STEP: mul_sel_q <= !e_q[0];
			ST_MUL_WAIT: if (mdone) begin
				if (!mul_sel_q && e_q[0]) begin
					x_q       <= mr;
					mul_sel_q <= 1'b1;
				end else begin
					a_q <= mr;
					e_q <= e_q >> 1;
				end
			end
			ST_CHECK: if (!(x_q == Width'(1) || x_q == nm1) && r_q >= s_q) prime_q <= 1'b0;
			ST_SQ_WAIT: if (mdone) begin
				x_q <= mr;
				r_q <= r_q + 1'b1;
				if (mr != nm1 && r_q + 1'b1 >= s_q) prime_q <= 1'b0;
			end
			default: ;
		endcase
	end
endmodule
`default_nettype wire

FILE: rtl/miller_rabin_prime_test_core.sv
`default_nettype none
// Deterministic Miller-Rabin primality test for one unsigned 64-bit candidate per item;
// each input item yields exactly one output item whose bit 0 says whether it is prime.
// The front stage rejects values below two and trial-divides by the primes up to 17;
// a two-entry queue then hands every classified candidate to the back stage, which
// runs witness rounds for the undecided ones with bases 2 to 37 (bases not below the
// candidate skipped). Every modular product goes through one shared shift-and-add unit.
// A round needs at most about 126 products (two per bit of the odd part of the
// candidate minus one, plus the squarings), so a prime costs up to about 12 * 126
// products, while most composites finish after the first base. Items leave in
// arrival order.
module miller_rabin_prime_test_core import mrpt_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [63:0] s_axis_tdata,  // [63:0] candidate
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [7:0]       m_axis_tdata   // [0] is_prime, [7:1] zero
);
	logic fj_valid, fj_ready, qj_valid, qj_ready, prime;
	job_t fj, qj;

	mrpt_front u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.in_n(s_axis_tdata), .job_valid(fj_valid), .job_ready(fj_ready), .job(fj)
	);

	mrpt_queue u_queue (
		.clk(clk), .arst_n(arst_n), .wr_valid(fj_valid), .wr_ready(fj_ready), .wr_job(fj),
		.rd_valid(qj_valid), .rd_ready(qj_ready), .rd_job(qj)
	);

	mrpt_back u_back (
		.clk(clk), .arst_n(arst_n), .job_valid(qj_valid), .job_ready(qj_ready), .job(qj),
		.res_valid(m_axis_tvalid), .res_ready(m_axis_tready), .res_prime(prime)
	);

	assign m_axis_tdata = {7'd0, prime};
endmodule
`default_nettype wire

FILE: tb/testbench.sv
`default_nettype none
module testbench;
	import mrpt_pkg::*;

	localparam int LIMIT = 40000000;

	typedef struct {
		logic [63:0] cand;
		bit          fixed;
		logic        verdict;
	} cand_item_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [63:0] s_axis_tdata = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [7:0]  m_axis_tdata;

	cand_item_t  send_q[$];
	cand_item_t  verdict_q[$];
	cand_item_t  cur;
	bit          calm = 1'b0;
	int          errors = 0;
	int          cycles = 0;

	miller_rabin_prime_test_core dut (.*);

	always #10 clk = ~clk;

	function automatic logic [63:0] mul_mod(logic [63:0] a, logic [63:0] b, logic [63:0] n);
		logic [127:0] p;
		p = {64'd0, a} * {64'd0, b};
		return 64'(p % {64'd0, n});
	endfunction

	function automatic logic [63:0] pow_mod(logic [63:0] a, logic [63:0] e, logic [63:0] n);
		logic [63:0] r;
		r = 64'd1 % n;
		while (e != 0) begin
			if (e[0]) r = mul_mod(r, a, n);
			a = mul_mod(a, a, n);
			e = e >> 1;
		end
		return r;
	endfunction

	function automatic logic witness_passes(logic [63:0] a, logic [63:0] n,
			logic [63:0] d, int s);
		logic [63:0] x;
		a = a % n;
		if (a == 0) return 1'b1;
		x = pow_mod(a, d, n);
		if (x == 1 || x == n - 1) return 1'b1;
		for (int r = 1; r < s; r++) begin
			x = mul_mod(x, x, n);
			if (x == n - 1) return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic logic prime_verdict(logic [63:0] n);
		logic [63:0] bases[12];
		logic [63:0] d;
		int s;
		bases = '{2, 3, 5, 7, 11, 13, 17, 19, 23, 29, 31, 37};
		s = 0;
		if (n < 2) return 1'b0;
		for (int i = 0; i < 7; i++)
			if (n % bases[i] == 0) return n == bases[i];
		d = n - 1;
		while (!d[0]) begin
			d = d >> 1;
			s++;
		end
		// The bases above 17 are skipped once they reach the candidate.
		for (int i = 0; i < 12; i++) begin
			if (i >= 7 && bases[i] >= n) continue;
			if (!witness_passes(bases[i], n, d, s)) return 1'b0;
		end
		return 1'b1;
	endfunction

	// Source side: the expectation is recorded when the item is accepted.
	always @(posedge clk or negedge arst_n) begin
		bit busy;
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else begin
			busy = s_axis_tvalid;
			if (s_axis_tvalid && s_axis_tready) begin
				if (!cur.fixed) cur.verdict = prime_verdict(cur.cand);
				verdict_q = {verdict_q, cur};
				busy = 1'b0;
			end
			if (!busy) begin
				if (send_q.size() > 0 && (calm || $urandom_range(99) >= 16)) begin
					cur = send_q.pop_front();
					s_axis_tdata <= cur.cand;
					s_axis_tvalid <= 1'b1;
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// Sink side: each verdict is checked against the oldest expectation.
	always @(posedge clk) begin
		cand_item_t e;
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (verdict_q.size() == 0) begin
					errors++;
					if (errors <= 10) $display("unexpected verdict %h", m_axis_tdata);
				end else begin
					e = verdict_q.pop_front();
					if (m_axis_tdata !== {7'd0, e.verdict}) begin
						errors++;
						if (errors <= 10)
							$display("candidate %0d: expected %0d, got %h",
								e.cand, e.verdict, m_axis_tdata);
					end
				end
			end
			m_axis_tready <= calm || $urandom_range(99) >= 16;
			cycles++;
			if (cycles > LIMIT) begin
				$display("DONE: errors detected");
				$finish;
			end
		end
	end

	task automatic queue_cand(logic [63:0] c, bit fixed, logic v);
		cand_item_t it;
		it.cand = c;
		it.fixed = fixed;
		it.verdict = v;
		send_q = {send_q, it};
	endtask

	initial begin
		cand_item_t table_rows[$];
		logic [63:0] c;
		int pick;
		// Fixed expectations only for the trivial and trial-division cases.
		table_rows = '{
			'{64'd0, 1, 0}, '{64'd1, 1, 0}, '{64'd2, 1, 1}, '{64'd3, 1, 1},
			'{64'd4, 1, 0}, '{64'd17, 1, 1}, '{64'd19, 0, 0}, '{64'd37, 0, 0},
			'{64'd41, 0, 0}, '{64'd561, 1, 0}, '{64'd1369, 0, 0},
			'{64'hFFFF_FFFF_FFFF_FFFF, 1, 0},
			'{64'hFFFF_FFFF_FFFF_FFC5, 0, 0},  // largest prime below 2^64
			'{64'd3215031751, 0, 0},          // strong pseudoprime to 2, 3, 5, 7
			'{64'd341550071728321, 0, 0},     // passes bases up to 17
			'{64'h8000_0000_0000_0000, 1, 0}, '{64'h8000_0000_0000_0001, 0, 0},
			'{64'h1FFF_FFFF_FFFF_FFFF, 0, 0}, '{64'd65537, 0, 0},
			'{64'hAAAA_AAAA_AAAA_AAAB, 0, 0}, '{64'h5555_5555_5555_5555, 1, 0}
		};
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		foreach (table_rows[i]) send_q = {send_q, table_rows[i]};
		for (int i = 0; i < 80; i++) begin
			pick = $urandom_range(99);
			if (pick < 70) c = $urandom_range(65535);
			else if (pick < 85) c = {$urandom, $urandom};
			else c = {32'd0, $urandom | 32'd1};
			queue_cand(c, 0, 0);
		end
		// Run a stretch of the random part with both sides always ready.
		wait (send_q.size() < 60);
		calm = 1'b1;
		wait (send_q.size() < 30);
		calm = 1'b0;
		wait (send_q.size() == 0 && !s_axis_tvalid && verdict_q.size() == 0);
		repeat (200) @(posedge clk);
		if (errors == 0 && verdict_q.size() == 0) $display("DONE: 0 errors");
		else $display("DONE: errors detected");
		$finish;
	end
endmodule
`default_nettype wire
